[hdl/mfpvc_pkg.sv]
package mfpvc_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int MAX_FACES    = 131072;

    localparam int IDX_W   = 16;
    localparam int FACE_W  = 17;
    localparam int NV_W    = 17;
    localparam int NF_W    = 18;
    localparam int EP_W    = 8;
    localparam int VDEPTH  = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
    localparam int VA_W    = $clog2(VDEPTH);
    localparam int QDEPTH  = 4;
    localparam int QA_W    = $clog2(QDEPTH);

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_START = 2'd1,
        FUNC_FACE  = 2'd2
    } t_func;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FACE   = 1'b1;

    typedef struct packed {
        logic             is_start;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef struct packed {
        logic [EP_W-1:0]  epoch;
        logic [IDX_W-1:0] idx;
    } t_remap;

    localparam int REMAP_W = $bits(t_remap);

    function automatic logic in_range(input logic [IDX_W-1:0] v);
        return int'(v) < MAX_VERTICES;
    endfunction

endpackage

[hdl/mfpvc_ram.sv]
module mfpvc_ram #(
    parameter int W = 1,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mfpvc_fifo.sv]
module mfpvc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mfpvc_pkg::t_q_wr     i_wr,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output mfpvc_pkg::t_cmd      o_head
);

    mfpvc_pkg::t_cmd              r_entry [mfpvc_pkg::QDEPTH];
    logic [mfpvc_pkg::QA_W-1:0]   r_wp;
    logic [mfpvc_pkg::QA_W-1:0]   r_rp;
    logic [mfpvc_pkg::QA_W:0]     r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == (mfpvc_pkg::QA_W+1)'(mfpvc_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rp];
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_wr.cmd;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/mfpvc_front.sv]
module mfpvc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  mfpvc_pkg::t_func                    i_func,
    input  logic [mfpvc_pkg::IDX_W-1:0]         i_vertex_index,
    input  logic                                i_vertex_inside,
    input  logic [mfpvc_pkg::IDX_W-1:0]         i_corner_a,
    input  logic [mfpvc_pkg::IDX_W-1:0]         i_corner_b,
    input  logic [mfpvc_pkg::IDX_W-1:0]         i_corner_c,
    input  logic                                i_q_full,
    input  mfpvc_pkg::t_back_status             i_back,
    output mfpvc_pkg::t_q_wr                    o_q_wr
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_RD_B,
        F_RD_C,
        F_DECIDE
    } t_fstate;

    t_fstate                         r_state, n_state;
    logic                            r_keep_side;
    logic [mfpvc_pkg::IDX_W-1:0]     r_a, r_b, r_c, n_a, n_b, n_c;
    logic                            r_fa, r_fb, n_fa, n_fb;

    logic                            accept;
    logic                            flag_we;
    logic [mfpvc_pkg::VA_W-1:0]      flag_waddr;
    logic [mfpvc_pkg::VA_W-1:0]      flag_raddr;
    logic                            flag_rdata;
    logic                            all_in;

    assign o_ready = (r_state == F_IDLE) && !i_q_full && !i_back.clearing;
    assign accept  = i_valid && o_ready;
    assign all_in  = r_fa & r_fb & flag_rdata;

    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        n_fa       = r_fa;
        n_fb       = r_fb;
        flag_we    = 1'b0;
        flag_waddr = i_vertex_index[mfpvc_pkg::VA_W-1:0];
        flag_raddr = i_corner_a[mfpvc_pkg::VA_W-1:0];
        o_q_wr     = '0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    case (i_func)
                        mfpvc_pkg::FUNC_SET: begin
                            flag_we = mfpvc_pkg::in_range(i_vertex_index);
                        end
                        mfpvc_pkg::FUNC_START: begin
                            o_q_wr.push         = 1'b1;
                            o_q_wr.cmd.is_start = 1'b1;
                        end
                        mfpvc_pkg::FUNC_FACE: begin
                            if (mfpvc_pkg::in_range(i_corner_a) &&
                                mfpvc_pkg::in_range(i_corner_b) &&
                                mfpvc_pkg::in_range(i_corner_c)) begin
                                n_a     = i_corner_a;
                                n_b     = i_corner_b;
                                n_c     = i_corner_c;
                                n_state = F_RD_B;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            F_RD_B: begin
                flag_raddr = r_b[mfpvc_pkg::VA_W-1:0];
                n_fa       = flag_rdata;
                n_state    = F_RD_C;
            end
            F_RD_C: begin
                flag_raddr = r_c[mfpvc_pkg::VA_W-1:0];
                n_fb       = flag_rdata;
                n_state    = F_DECIDE;
            end
            F_DECIDE: begin
                flag_raddr          = r_c[mfpvc_pkg::VA_W-1:0];
                o_q_wr.push         = (all_in == r_keep_side);
                o_q_wr.cmd.is_start = 1'b0;
                o_q_wr.cmd.a        = r_a;
                o_q_wr.cmd.b        = r_b;
                o_q_wr.cmd.c        = r_c;
                n_state             = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_b  <= n_b;
        r_c  <= n_c;
        r_fa <= n_fa;
        r_fb <= n_fb;
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_keep_side <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_keep_side <= i_cfg_wdata;
            end
        end
    end

    mfpvc_ram #(
        .W(1),
        .D(mfpvc_pkg::VDEPTH)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (i_vertex_inside),
        .i_raddr (flag_raddr),
        .o_rdata (flag_rdata)
    );

endmodule

[hdl/mfpvc_back.sv]
module mfpvc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  mfpvc_pkg::t_cmd                 i_q_head,
    output logic                            o_pop,
    output mfpvc_pkg::t_back_status         o_status,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_kind,
    output logic [mfpvc_pkg::IDX_W-1:0]     o_old_vertex,
    output logic [mfpvc_pkg::IDX_W-1:0]     o_new_vertex,
    output logic [mfpvc_pkg::FACE_W-1:0]    o_face_number,
    output logic [mfpvc_pkg::IDX_W-1:0]     o_new_a,
    output logic [mfpvc_pkg::IDX_W-1:0]     o_new_b,
    output logic [mfpvc_pkg::IDX_W-1:0]     o_new_c,
    output logic                            o_last
);

    typedef enum logic [1:0] {
        B_CLR,
        B_IDLE,
        B_LOOK,
        B_FACE
    } t_bstate;

    t_bstate                           r_state, n_state;
    logic [1:0]                        r_ci, n_ci;
    mfpvc_pkg::t_cmd                   r_cmd, n_cmd;
    logic [mfpvc_pkg::IDX_W-1:0]       r_ren_a, r_ren_b, r_ren_c;
    logic [mfpvc_pkg::IDX_W-1:0]       n_ren_a, n_ren_b, n_ren_c;
    logic [mfpvc_pkg::NV_W-1:0]        r_next_vertex, n_next_vertex;
    logic [mfpvc_pkg::NF_W-1:0]        r_next_face, n_next_face;
    logic [mfpvc_pkg::EP_W-1:0]        r_epoch, n_epoch;
    logic [mfpvc_pkg::VA_W-1:0]        r_clr_addr, n_clr_addr;

    logic                              r_out_valid, n_out_valid;
    logic                              r_out_kind, n_out_kind;
    logic [mfpvc_pkg::IDX_W-1:0]       r_out_old, n_out_old;
    logic [mfpvc_pkg::IDX_W-1:0]       r_out_newv, n_out_newv;
    logic [mfpvc_pkg::FACE_W-1:0]      r_out_face, n_out_face;
    logic [mfpvc_pkg::IDX_W-1:0]       r_out_a, r_out_b, r_out_c;
    logic [mfpvc_pkg::IDX_W-1:0]       n_out_a, n_out_b, n_out_c;
    logic                              r_out_last, n_out_last;

    logic                              out_free;
    logic [mfpvc_pkg::IDX_W-1:0]       cur;
    logic [mfpvc_pkg::IDX_W-1:0]       nxt;
    logic                              dup;
    logic [mfpvc_pkg::IDX_W-1:0]       dup_ren;
    logic                              go;
    logic [mfpvc_pkg::IDX_W-1:0]       ren;
    logic                              ram_we;
    logic [mfpvc_pkg::VA_W-1:0]        ram_waddr;
    mfpvc_pkg::t_remap                 ram_wdata;
    logic [mfpvc_pkg::VA_W-1:0]        ram_raddr;
    mfpvc_pkg::t_remap                 ram_rdata;

    assign out_free          = !r_out_valid || i_ready;
    assign o_status.clearing = (r_state == B_CLR);

    always_comb begin
        case (r_ci)
            2'd0:    cur = r_cmd.a;
            2'd1:    cur = r_cmd.b;
            default: cur = r_cmd.c;
        endcase
        nxt = (r_ci == 2'd0) ? r_cmd.b : r_cmd.c;
        dup     = 1'b0;
        dup_ren = r_ren_a;
        if (r_ci == 2'd1 && r_cmd.b == r_cmd.a) begin
            dup = 1'b1;
        end else if (r_ci == 2'd2 && r_cmd.c == r_cmd.a) begin
            dup = 1'b1;
        end else if (r_ci == 2'd2 && r_cmd.c == r_cmd.b) begin
            dup     = 1'b1;
            dup_ren = r_ren_b;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_ci          = r_ci;
        n_cmd         = r_cmd;
        n_ren_a       = r_ren_a;
        n_ren_b       = r_ren_b;
        n_ren_c       = r_ren_c;
        n_next_vertex = r_next_vertex;
        n_next_face   = r_next_face;
        n_epoch       = r_epoch;
        n_clr_addr    = r_clr_addr;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_kind    = r_out_kind;
        n_out_old     = r_out_old;
        n_out_newv    = r_out_newv;
        n_out_face    = r_out_face;
        n_out_a       = r_out_a;
        n_out_b       = r_out_b;
        n_out_c       = r_out_c;
        n_out_last    = r_out_last;
        o_pop         = 1'b0;
        go            = 1'b0;
        ren           = dup_ren;
        ram_we        = 1'b0;
        ram_waddr     = cur[mfpvc_pkg::VA_W-1:0];
        ram_wdata     = '0;
        ram_raddr     = cur[mfpvc_pkg::VA_W-1:0];
        case (r_state)
            B_CLR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == mfpvc_pkg::VA_W'(mfpvc_pkg::VDEPTH - 1)) begin
                    n_epoch = mfpvc_pkg::EP_W'(1);
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                ram_raddr = i_q_head.a[mfpvc_pkg::VA_W-1:0];
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_head;
                    if (i_q_head.is_start) begin
                        n_next_vertex = '0;
                        n_next_face   = '0;
                        if (r_epoch == {mfpvc_pkg::EP_W{1'b1}}) begin
                            n_clr_addr = '0;
                            n_state    = B_CLR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end else if (int'(r_next_face) < mfpvc_pkg::MAX_FACES) begin
                        n_ci    = 2'd0;
                        n_state = B_LOOK;
                    end
                end
            end
            B_LOOK: begin
                if (dup) begin
                    go = 1'b1;
                end else if (ram_rdata.epoch == r_epoch) begin
                    go  = 1'b1;
                    ren = ram_rdata.idx;
                end else if (out_free) begin
                    go              = 1'b1;
                    ren             = r_next_vertex[mfpvc_pkg::IDX_W-1:0];
                    ram_we          = 1'b1;
                    ram_wdata.epoch = r_epoch;
                    ram_wdata.idx   = ren;
                    n_next_vertex   = r_next_vertex + 1'b1;
                    n_out_valid     = 1'b1;
                    n_out_kind      = mfpvc_pkg::KIND_VERTEX;
                    n_out_old       = cur;
                    n_out_newv      = ren;
                    n_out_face      = '0;
                    n_out_a         = '0;
                    n_out_b         = '0;
                    n_out_c         = '0;
                    n_out_last      = 1'b0;
                end
                if (go) begin
                    ram_raddr = nxt[mfpvc_pkg::VA_W-1:0];
                    case (r_ci)
                        2'd0:    n_ren_a = ren;
                        2'd1:    n_ren_b = ren;
                        default: n_ren_c = ren;
                    endcase
                    if (r_ci == 2'd2) begin
                        n_state = B_FACE;
                    end else begin
                        n_ci = r_ci + 1'b1;
                    end
                end
            end
            B_FACE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = mfpvc_pkg::KIND_FACE;
                    n_out_old   = '0;
                    n_out_newv  = '0;
                    n_out_face  = r_next_face[mfpvc_pkg::FACE_W-1:0];
                    n_out_a     = r_ren_a;
                    n_out_b     = r_ren_b;
                    n_out_c     = r_ren_c;
                    n_out_last  = 1'b1;
                    n_next_face = r_next_face + 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ci       <= n_ci;
        r_cmd      <= n_cmd;
        r_ren_a    <= n_ren_a;
        r_ren_b    <= n_ren_b;
        r_ren_c    <= n_ren_c;
        r_out_kind <= n_out_kind;
        r_out_old  <= n_out_old;
        r_out_newv <= n_out_newv;
        r_out_face <= n_out_face;
        r_out_a    <= n_out_a;
        r_out_b    <= n_out_b;
        r_out_c    <= n_out_c;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_state       <= B_CLR;
            r_clr_addr    <= '0;
            r_epoch       <= '0;
            r_next_vertex <= '0;
            r_next_face   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_epoch       <= n_epoch;
            r_next_vertex <= n_next_vertex;
            r_next_face   <= n_next_face;
            r_out_valid   <= n_out_valid;
        end
    end

    mfpvc_ram #(
        .W(mfpvc_pkg::REMAP_W),
        .D(mfpvc_pkg::VDEPTH)
    ) u_remap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_old_vertex  = r_out_old;
    assign o_new_vertex  = r_out_newv;
    assign o_face_number = r_out_face;
    assign o_new_a       = r_out_a;
    assign o_new_b       = r_out_b;
    assign o_new_c       = r_out_c;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_CLR |-> !o_pop)
        else $error("queue popped during remap clear");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != B_CLR |-> r_epoch != '0)
        else $error("cleared epoch in use");

    a_face_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FACE && out_free) |=> (r_out_valid && r_out_last &&
        r_out_kind == mfpvc_pkg::KIND_FACE && r_state == B_IDLE))
        else $error("face record not issued");
`endif

endmodule

[hdl/mesh_face_partition_vertex_compactor.sv]
// Extracts one side of a cut through a triangle mesh and renumbers its vertices densely.
// The input stream carries set-flag, start-pass and face beats, selected by s_axis_tuser.
// Set-flag beats write a vertex's inside bit; start-pass beats open a new numbering pass.
// Each kept face yields one vertex-copy beat per newly met corner and then one face beat
// with tlast set; dropped faces yield nothing. i_cfg_we loads the keep-side bit; the user
// must do so only while idle, as the block does not enforce it. The front end reads the
// three corner flags one after another on the single read port of the flag memory, in
// F_IDLE, F_RD_B and F_RD_C, and decides in F_DECIDE, taking no new beat until a face is
// done; a set-flag or start-pass beat is handled in F_IDLE itself. The back end looks up
// the three corners on the remap memory read port one after another in B_LOOK and then
// emits the face beat in B_FACE, waiting while it has a beat to emit and the output
// register cannot take it; the two ends are joined by a four-entry command queue.
// After reset all 65536 remap memory entries are cleared, while s_axis_tready is low.
// Each start pass moves to a new epoch; every 255th start pass repeats the full clear.
// When m_axis_tready is low, the output register holds its beat, the back end waits and
// the queue fills, after which s_axis_tready goes low.
module mesh_face_partition_vertex_compactor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // vertex_index, vertex_inside, corner_a, corner_b, corner_c, zero fill
    input  logic [mfpvc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func
    input  logic [mfpvc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // old_vertex, new_vertex, face_number, new_a, new_b, new_c, zero fill
    output logic [mfpvc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // kind
    output logic [0:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);

    mfpvc_pkg::t_q_wr                 q_wr;
    logic                             q_full;
    logic                             q_empty;
    logic                             q_pop;
    mfpvc_pkg::t_cmd                  q_head;
    mfpvc_pkg::t_back_status          back_status;
    logic                             out_kind;
    logic [mfpvc_pkg::IDX_W-1:0]      out_old;
    logic [mfpvc_pkg::IDX_W-1:0]      out_newv;
    logic [mfpvc_pkg::FACE_W-1:0]     out_face;
    logic [mfpvc_pkg::IDX_W-1:0]      out_a;
    logic [mfpvc_pkg::IDX_W-1:0]      out_b;
    logic [mfpvc_pkg::IDX_W-1:0]      out_c;

    mfpvc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_func          (mfpvc_pkg::t_func'(s_axis_tuser)),
        .i_vertex_index  (s_axis_tdata[15:0]),
        .i_vertex_inside (s_axis_tdata[16]),
        .i_corner_a      (s_axis_tdata[32:17]),
        .i_corner_b      (s_axis_tdata[48:33]),
        .i_corner_c      (s_axis_tdata[64:49]),
        .i_q_full        (q_full),
        .i_back          (back_status),
        .o_q_wr          (q_wr)
    );

    mfpvc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    mfpvc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_pop         (q_pop),
        .o_status      (back_status),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (out_kind),
        .o_old_vertex  (out_old),
        .o_new_vertex  (out_newv),
        .o_face_number (out_face),
        .o_new_a       (out_a),
        .o_new_b       (out_b),
        .o_new_c       (out_c),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {7'd0, out_c, out_b, out_a, out_face, out_newv, out_old};

endmodule
